// ----- rtl/lir_pkg.sv -----
package lir_pkg;

  // number formats
  localparam int FRAC_BITS   = 12;
  localparam int SAMPLE_BITS = 16;
  localparam int VALUE_BITS  = 20;
  localparam int POS_BITS    = 24;
  localparam int RATIO_BITS  = 16;
  localparam int BOARD_BITS  = 5;
  localparam int BOARD_COUNT = 32;
  localparam int MASK_BITS   = 32;
  localparam int MAX_RESULTS = 64;
  localparam int CNT_BITS    = $clog2(MAX_RESULTS + 1);
  localparam int ONE_POS     = 1 << FRAC_BITS;
  localparam int PROD_BITS   = SAMPLE_BITS + FRAC_BITS + 2;

  // ratios under 1/64 of a sample pass the waveform through
  localparam logic [RATIO_BITS-1:0] MIN_RATIO = RATIO_BITS'(ONE_POS >> 6);

  // apb register map
  localparam int ADDR_BITS = 4;
  localparam int DATA_BITS = 32;
  localparam logic [1:0] REG_RATIO  = 2'd0;
  localparam logic [1:0] REG_OFFSET = 2'd1;
  localparam logic [1:0] REG_MASK   = 2'd2;

  // datapath operations
  typedef enum logic [2:0] {
    OP_NOP,
    OP_MUL,
    OP_EMIT_INTERP,
    OP_ADVANCE,
    OP_MARK,
    OP_NEWWAVE,
    OP_EMIT_RAW,
    OP_EMIT_PASS
  } op_t;

  // jump conditions
  typedef enum logic [2:0] {
    CND_NEVER,
    CND_ALWAYS,
    CND_NOT_ACCEPT,
    CND_NEW_WAVE,
    CND_NOT_ACTIVE,
    CND_CONT_DONE,
    CND_START_DONE,
    CND_NO_MARK
  } cond_t;

  // program steps
  typedef enum logic [3:0] {
    ST_WAIT,
    ST_DISP,
    ST_DISP2,
    ST_C_MUL,
    ST_C_EMIT,
    ST_C_END,
    ST_C_MARK,
    ST_S_NEW,
    ST_S_ACT,
    ST_S_TST,
    ST_S_EMIT,
    ST_PASS,
    ST_S_END,
    ST_S_MARK
  } step_t;

  typedef struct packed {
    op_t   op;
    logic  fin;
    cond_t cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic accept;
    logic new_wave;
    logic active;
    logic cont_done;
    logic start_done;
    logic mark_due;
    logic out_full;
  } stat_t;

  // control store: one word per step
  function automatic ctrl_t ucode(input step_t s);
    ctrl_t c;
    c = '{op: OP_NOP, fin: 1'b0, cond: CND_ALWAYS, target: ST_WAIT};
    case (s)
      ST_WAIT:   c = '{op: OP_NOP,         fin: 1'b0, cond: CND_NOT_ACCEPT, target: ST_WAIT};
      ST_DISP:   c = '{op: OP_NOP,         fin: 1'b0, cond: CND_NEW_WAVE,   target: ST_S_NEW};
      ST_DISP2:  c = '{op: OP_NOP,         fin: 1'b0, cond: CND_NOT_ACTIVE, target: ST_PASS};
      ST_C_MUL:  c = '{op: OP_MUL,         fin: 1'b0, cond: CND_CONT_DONE,  target: ST_C_END};
      ST_C_EMIT: c = '{op: OP_EMIT_INTERP, fin: 1'b0, cond: CND_ALWAYS,     target: ST_C_MUL};
      ST_C_END:  c = '{op: OP_ADVANCE,     fin: 1'b1, cond: CND_NO_MARK,    target: ST_WAIT};
      ST_C_MARK: c = '{op: OP_MARK,        fin: 1'b0, cond: CND_ALWAYS,     target: ST_WAIT};
      ST_S_NEW:  c = '{op: OP_NEWWAVE,     fin: 1'b0, cond: CND_NEVER,      target: ST_WAIT};
      ST_S_ACT:  c = '{op: OP_NOP,         fin: 1'b0, cond: CND_NOT_ACTIVE, target: ST_PASS};
      ST_S_TST:  c = '{op: OP_NOP,         fin: 1'b0, cond: CND_START_DONE, target: ST_S_END};
      ST_S_EMIT: c = '{op: OP_EMIT_RAW,    fin: 1'b0, cond: CND_ALWAYS,     target: ST_S_TST};
      ST_PASS:   c = '{op: OP_EMIT_PASS,   fin: 1'b1, cond: CND_ALWAYS,     target: ST_WAIT};
      ST_S_END:  c = '{op: OP_NOP,         fin: 1'b1, cond: CND_NO_MARK,    target: ST_WAIT};
      ST_S_MARK: c = '{op: OP_MARK,        fin: 1'b0, cond: CND_ALWAYS,     target: ST_WAIT};
      default:   c = '{op: OP_NOP,         fin: 1'b0, cond: CND_ALWAYS,     target: ST_WAIT};
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/lir_seq.sv -----
module lir_seq import lir_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  stat_t stat,
  output ctrl_t ctrl,
  output logic  hold,
  output logic  idle
);

  step_t step_r;
  step_t step_nxt;
  logic  take;
  logic  emits;

  // current control word
  assign ctrl = ucode(step_r);
  assign idle = (step_r == ST_WAIT);

  // emitting steps wait while the output register is full and stalled
  always_comb begin
    case (ctrl.op)
      OP_EMIT_INTERP, OP_EMIT_RAW, OP_EMIT_PASS, OP_MARK: emits = 1'b1;
      default:                                            emits = 1'b0;
    endcase
    hold = emits && stat.out_full;
  end

  // jump condition
  always_comb begin
    case (ctrl.cond)
      CND_NEVER:      take = 1'b0;
      CND_ALWAYS:     take = 1'b1;
      CND_NOT_ACCEPT: take = !stat.accept;
      CND_NEW_WAVE:   take = stat.new_wave;
      CND_NOT_ACTIVE: take = !stat.active;
      CND_CONT_DONE:  take = stat.cont_done;
      CND_START_DONE: take = stat.start_done;
      CND_NO_MARK:    take = !stat.mark_due;
      default:        take = 1'b0;
    endcase
  end

  // step counter
  always_comb begin
    if (hold) begin
      step_nxt = step_r;
    end else if (take) begin
      step_nxt = ctrl.target;
    end else begin
      step_nxt = step_t'(step_r + 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// ----- rtl/linear_interp_resampler.sv -----
// Linear-interpolation resampler, one waveform at a time. Items carry a sample with first and
// last marks; result j of a waveform lies at j*sampling_ratio - sampling_offset input samples
// (Q.12), positions at or before zero repeat sample 0, later ones interpolate between their two
// neighbours and leave once the upper one has arrived, values in Q16.4 floored. Waveforms whose
// board bit is clear, or any waveform while the ratio is under 1/64, pass through one result per
// item. A small microcoded sequencer runs one control word per cycle, holding on an emitting step
// while the output register is full and stalled, over a single multiplier: each interpolated
// result takes a multiply step and an emit step, a new waveform adds a setup step, and an empty
// last item sends an end marker. A new item is taken only once the sequencer is back in its
// wait step. At most 64 results leave per item. Configuration is to be written through the APB
// port only between items; the block itself does not enforce this.
module linear_interp_resampler import lir_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  // input items
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [BOARD_BITS-1:0]         in_board_id,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_first,
  input  logic                          in_last,
  // result items
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [VALUE_BITS-1:0]  out_value,
  output logic                          out_has_sample,
  output logic                          out_end_of_wave,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_BITS-1:0]          paddr,
  input  logic [DATA_BITS-1:0]          pwdata,
  output logic [DATA_BITS-1:0]          prdata,
  output logic                          pready
);

  ctrl_t ctrl;
  stat_t stat;
  logic  hold;
  logic  idle;
  logic  accept;
  logic  exec;
  logic  cfg_wr;

  // configuration registers
  logic [RATIO_BITS-1:0]         ratio_r,  ratio_nxt;
  logic [RATIO_BITS-1:0]         offset_r, offset_nxt;
  logic [MASK_BITS-1:0]          mask_r,   mask_nxt;

  // latched item
  logic [BOARD_BITS-1:0]         board_r,  board_nxt;
  logic signed [SAMPLE_BITS-1:0] y_r,      y_nxt;
  logic                          first_r,  first_nxt;
  logic                          last_r,   last_nxt;

  // waveform state
  logic signed [SAMPLE_BITS-1:0] prev_r,   prev_nxt;
  logic signed [POS_BITS-1:0]    q_r,      q_nxt;
  logic                          in_wave_r, in_wave_nxt;
  logic                          active_r, active_nxt;
  logic [CNT_BITS-1:0]           cnt_r,    cnt_nxt;
  logic signed [PROD_BITS-1:0]   prod_r,   prod_nxt;

  // output register
  logic                          out_valid_r, out_valid_nxt;
  logic signed [VALUE_BITS-1:0]  out_value_r, out_value_nxt;
  logic                          out_has_r,   out_has_nxt;
  logic                          out_eow_r,   out_eow_nxt;

  // datapath terms
  logic signed [POS_BITS:0]      q_sum;
  logic signed [POS_BITS:0]      q_dec;
  logic signed [POS_BITS:0]      q_start;
  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [FRAC_BITS:0]     wgt;
  logic signed [PROD_BITS-1:0]   acc;
  logic [VALUE_BITS-1:0]         raw_value;
  logic                          cnt_last;
  logic                          sel;

  localparam logic signed [POS_BITS:0] ONE_W  = (POS_BITS + 1)'(ONE_POS);
  localparam logic signed [POS_BITS:0] ZERO_W = (POS_BITS + 1)'(0);

  lir_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl),
    .hold  (hold),
    .idle  (idle)
  );

  assign accept   = in_valid && idle;
  assign in_stall = !idle;
  assign exec     = !hold;

  // position arithmetic
  always_comb begin
    q_sum    = {q_r[POS_BITS-1], q_r} + {{(POS_BITS + 1 - RATIO_BITS){1'b0}}, ratio_r};
    q_dec    = {q_r[POS_BITS-1], q_r} - ONE_W;
    q_start  = '0 - {{(POS_BITS + 1 - RATIO_BITS){offset_r[RATIO_BITS-1]}}, offset_r};
    cnt_last = (cnt_r == CNT_BITS'(MAX_RESULTS - 1));
    sel      = (int'(board_r) < BOARD_COUNT) && mask_r[board_r];
  end

  // interpolation terms
  always_comb begin
    diff      = {y_r[SAMPLE_BITS-1], y_r} - {prev_r[SAMPLE_BITS-1], prev_r};
    wgt       = q_r[POS_BITS-1] ? '0 : {1'b0, q_r[FRAC_BITS-1:0]};
    acc       = {{(PROD_BITS - SAMPLE_BITS - FRAC_BITS){prev_r[SAMPLE_BITS-1]}}, prev_r,
                 {FRAC_BITS{1'b0}}} + prod_r;
    raw_value = {y_r, {(VALUE_BITS - SAMPLE_BITS){1'b0}}};
  end

  // status to the sequencer
  always_comb begin
    stat.accept     = accept;
    stat.new_wave   = first_r || !in_wave_r;
    stat.active     = active_r;
    stat.cont_done  = (q_r >= $signed(POS_BITS'(ONE_POS))) ||
                      (cnt_r == CNT_BITS'(MAX_RESULTS));
    stat.start_done = (q_r > $signed(POS_BITS'(0))) || (cnt_r == CNT_BITS'(MAX_RESULTS));
    stat.mark_due   = last_r && (cnt_r == '0);
    stat.out_full   = out_valid_r && out_stall;
  end

  // configuration writes
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    ratio_nxt  = ratio_r;
    offset_nxt = offset_r;
    mask_nxt   = mask_r;
    if (cfg_wr) begin
      case (paddr[3:2])
        REG_RATIO:  ratio_nxt  = pwdata[RATIO_BITS-1:0];
        REG_OFFSET: offset_nxt = pwdata[RATIO_BITS-1:0];
        REG_MASK:   mask_nxt   = pwdata[MASK_BITS-1:0];
        default:    ratio_nxt  = ratio_r;
      endcase
    end
  end

  // configuration reads
  always_comb begin
    case (paddr[3:2])
      REG_RATIO:  prdata = {{(DATA_BITS - RATIO_BITS){1'b0}}, ratio_r};
      REG_OFFSET: prdata = {{(DATA_BITS - RATIO_BITS){1'b0}}, offset_r};
      REG_MASK:   prdata = mask_r;
      default:    prdata = '0;
    endcase
  end

  // datapath next state
  always_comb begin
    board_nxt     = board_r;
    y_nxt         = y_r;
    first_nxt     = first_r;
    last_nxt      = last_r;
    prev_nxt      = prev_r;
    q_nxt         = q_r;
    in_wave_nxt   = in_wave_r;
    active_nxt    = active_r;
    cnt_nxt       = cnt_r;
    prod_nxt      = prod_r;
    out_value_nxt = out_value_r;
    out_has_nxt   = out_has_r;
    out_eow_nxt   = out_eow_r;
    out_valid_nxt = out_valid_r && out_stall;

    // take in an item
    if (accept) begin
      board_nxt = in_board_id;
      y_nxt     = in_sample;
      first_nxt = in_first;
      last_nxt  = in_last;
      cnt_nxt   = '0;
    end

    if (exec) begin
      case (ctrl.op)
        OP_NEWWAVE: begin
          in_wave_nxt = 1'b1;
          active_nxt  = sel && (ratio_r >= MIN_RATIO);
          q_nxt       = q_start[POS_BITS-1:0];
        end
        OP_MUL: begin
          prod_nxt = diff * wgt;
        end
        OP_EMIT_INTERP: begin
          out_valid_nxt = 1'b1;
          out_value_nxt = acc[FRAC_BITS + VALUE_BITS - 5:FRAC_BITS - 4];
          out_has_nxt   = 1'b1;
          out_eow_nxt   = last_r && (cnt_last || (q_sum >= ONE_W));
          q_nxt         = q_sum[POS_BITS-1:0];
          cnt_nxt       = cnt_r + 1'b1;
        end
        OP_EMIT_RAW: begin
          out_valid_nxt = 1'b1;
          out_value_nxt = raw_value;
          out_has_nxt   = 1'b1;
          out_eow_nxt   = last_r && (cnt_last || (q_sum > ZERO_W));
          q_nxt         = q_sum[POS_BITS-1:0];
          cnt_nxt       = cnt_r + 1'b1;
        end
        OP_EMIT_PASS: begin
          out_valid_nxt = 1'b1;
          out_value_nxt = raw_value;
          out_has_nxt   = 1'b1;
          out_eow_nxt   = last_r;
          cnt_nxt       = cnt_r + 1'b1;
        end
        OP_MARK: begin
          out_valid_nxt = 1'b1;
          out_value_nxt = '0;
          out_has_nxt   = 1'b0;
          out_eow_nxt   = 1'b1;
          cnt_nxt       = cnt_r + 1'b1;
        end
        OP_ADVANCE: begin
          // step one sample on, saturating to the position range
          if (q_dec[POS_BITS] != q_dec[POS_BITS-1]) begin
            q_nxt = q_dec[POS_BITS] ? {1'b1, {(POS_BITS - 1){1'b0}}}
                                    : {1'b0, {(POS_BITS - 1){1'b1}}};
          end else begin
            q_nxt = q_dec[POS_BITS-1:0];
          end
        end
        default: begin
          q_nxt = q_r;
        end
      endcase

      // item done: remember the sample, close the waveform on its last item
      if (ctrl.fin) begin
        prev_nxt = y_r;
        if (last_r) begin
          in_wave_nxt = 1'b0;
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r     <= RATIO_BITS'(ONE_POS);
      offset_r    <= '0;
      mask_r      <= '0;
      in_wave_r   <= 1'b0;
      active_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ratio_r     <= ratio_nxt;
      offset_r    <= offset_nxt;
      mask_r      <= mask_nxt;
      in_wave_r   <= in_wave_nxt;
      active_r    <= active_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    board_r     <= board_nxt;
    y_r         <= y_nxt;
    first_r     <= first_nxt;
    last_r      <= last_nxt;
    prev_r      <= prev_nxt;
    q_r         <= q_nxt;
    prod_r      <= prod_nxt;
    out_value_r <= out_value_nxt;
    out_has_r   <= out_has_nxt;
    out_eow_r   <= out_eow_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_value       = out_value_r;
  assign out_has_sample  = out_has_r;
  assign out_end_of_wave = out_eow_r;

  // an accepted item always starts the program
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !idle)
    else $error("sequencer stayed idle after taking an item");

  // never more than the result limit per item
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.op == OP_EMIT_INTERP || ctrl.op == OP_EMIT_RAW |-> cnt_r < CNT_BITS'(MAX_RESULTS))
    else $error("result count overran its limit");

  // an end marker closes the waveform and carries a zero value
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_has_r |-> out_eow_r && out_value_r == '0)
    else $error("malformed end marker");

  // finishing the last item leaves the waveform closed
  a_wave_closed: assert property (@(posedge clk) disable iff (!rst_n)
    exec && ctrl.fin && last_r |=> !in_wave_r)
    else $error("waveform still open after its last item");

endmodule

// ----- tb/tb_linear_interp_resampler.sv -----
module tb_linear_interp_resampler;
  import lir_pkg::*;

  localparam int CYCLE_LIMIT   = 1500000;
  localparam int SETTLE_CYCLES = 160;
  localparam int TOTAL_ITEMS   = 310;
  localparam int PRINT_LIMIT   = 60;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic                         has_sample;
    logic                         end_of_wave;
  } wave_result_t;

  logic                          clk;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [BOARD_BITS-1:0]         in_board_id = '0;
  logic signed [SAMPLE_BITS-1:0] in_sample = '0;
  logic                          in_first = 1'b0;
  logic                          in_last = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [VALUE_BITS-1:0]  out_value;
  logic                          out_has_sample;
  logic                          out_end_of_wave;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [ADDR_BITS-1:0]          paddr = '0;
  logic [DATA_BITS-1:0]          pwdata = '0;
  logic [DATA_BITS-1:0]          prdata;
  logic                          pready;

  linear_interp_resampler dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_board_id     (in_board_id),
    .in_sample       (in_sample),
    .in_first        (in_first),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_value       (out_value),
    .out_has_sample  (out_has_sample),
    .out_end_of_wave (out_end_of_wave),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // resampler state as the testbench sees it
  logic [RATIO_BITS-1:0]         ratio_reg = 16'd4096;
  logic signed [15:0]            offset_reg = '0;
  logic [MASK_BITS-1:0]          mask_reg = '0;
  logic signed [SAMPLE_BITS-1:0] last_sample = '0;
  logic signed [POS_BITS-1:0]    pending_pos = '0;
  logic                          wave_resampled = 1'b0;
  logic                          wave_open = 1'b0;

  wave_result_t expected_results[$];

  int  errors = 0;
  int  items_sent = 0;
  int  cycle_count = 0;
  int  burst_left = 0;
  bit  offering = 1'b0;
  bit  no_gaps = 1'b0;
  int  stall_mode = 0;
  int  hold_req = 0;
  logic [7:0] stall_pat = 8'h5a;
  int  pat_age = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("linear_interp_resampler regression: fail");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (errors < PRINT_LIMIT)
      $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycle_count);
    errors++;
  endtask

  // expected results of one accepted item
  task automatic predict_item(input logic [BOARD_BITS-1:0] bid,
                              input logic signed [SAMPLE_BITS-1:0] smp,
                              input logic fst, input logic lst);
    longint       pos, y, y1, w, v, step;
    wave_result_t batch[$];
    wave_result_t r;
    y = smp;
    step = ratio_reg;
    if (fst || !wave_open) begin
      wave_open = 1'b1;
      wave_resampled = (bid < BOARD_COUNT) && mask_reg[bid] && (ratio_reg >= MIN_RATIO);
      if (wave_resampled) begin
        // positions at or before zero repeat the first sample
        pos = -longint'(offset_reg);
        while (pos <= 0 && batch.size() < MAX_RESULTS) begin
          r = '{value: VALUE_BITS'(y * 16), has_sample: 1'b1, end_of_wave: 1'b0};
          batch.insert(batch.size(), r);
          pos += step;
        end
        if (pos > (longint'(1) << 23) - 1) pos = (longint'(1) << 23) - 1;
        if (pos < -(longint'(1) << 23)) pos = -(longint'(1) << 23);
        pending_pos = POS_BITS'(pos);
      end else begin
        r = '{value: VALUE_BITS'(y * 16), has_sample: 1'b1, end_of_wave: 1'b0};
        batch.insert(batch.size(), r);
      end
    end else if (wave_resampled) begin
      // interpolate every position below the new sample, overdue ones at weight zero
      pos = pending_pos;
      y1 = last_sample;
      while (pos < ONE_POS && batch.size() < MAX_RESULTS) begin
        w = (pos < 0) ? 0 : pos;
        v = y1 * ONE_POS + (y - y1) * w;
        r = '{value: VALUE_BITS'(v >>> (FRAC_BITS - 4)), has_sample: 1'b1, end_of_wave: 1'b0};
        batch.insert(batch.size(), r);
        pos += step;
      end
      pos -= ONE_POS;
      if (pos > (longint'(1) << 23) - 1) pos = (longint'(1) << 23) - 1;
      if (pos < -(longint'(1) << 23)) pos = -(longint'(1) << 23);
      pending_pos = POS_BITS'(pos);
    end else begin
      r = '{value: VALUE_BITS'(y * 16), has_sample: 1'b1, end_of_wave: 1'b0};
      batch.insert(batch.size(), r);
    end
    last_sample = smp;
    if (lst) begin
      // a silent last item still closes the waveform with a marker
      if (batch.size() == 0) begin
        r = '{value: '0, has_sample: 1'b0, end_of_wave: 1'b0};
        batch.insert(batch.size(), r);
      end
      batch[batch.size()-1].end_of_wave = 1'b1;
      wave_open = 1'b0;
    end
    foreach (batch[i]) expected_results.insert(expected_results.size(), batch[i]);
  endtask

  // offer one item, keep valid high inside a burst
  task automatic send_item(input logic [BOARD_BITS-1:0] bid,
                           input logic signed [SAMPLE_BITS-1:0] smp,
                           input logic fst, input logic lst);
    in_valid    <= 1'b1;
    in_board_id <= bid;
    in_sample   <= smp;
    in_first    <= fst;
    in_last     <= lst;
    offering = 1'b1;
    do @(posedge clk); while (in_stall);
    predict_item(bid, smp, fst, lst);
    items_sent++;
    if (!no_gaps) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        in_valid <= 1'b0;
        offering = 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        burst_left = $urandom_range(0, 9);
      end
    end
  endtask

  // stop offering, wait for every expected result, then let the block go idle
  task automatic drain_results;
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write followed by a read back
  task automatic cfg_write(input logic [1:0] reg_idx, input logic [DATA_BITS-1:0] data);
    logic [DATA_BITS-1:0] want;
    logic [DATA_BITS-1:0] keep;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (reg_idx)
      REG_RATIO: begin
        ratio_reg = data[15:0];
        keep = 32'h0000_ffff;
      end
      REG_OFFSET: begin
        offset_reg = data[15:0];
        keep = 32'h0000_ffff;
      end
      default: begin
        mask_reg = data;
        keep = 32'hffff_ffff;
      end
    endcase
    want = data & keep;
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if ((prdata & keep) != want)
      report_mismatch("register read back", prdata & keep, want);
  endtask

  // result checker and receiver stall pattern
  always @(posedge clk) begin : result_monitor
    wave_result_t want;
    logic         stall_next;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with none expected, value", out_value, 0);
      end else begin
        want = expected_results.pop_front();
        if (out_value !== want.value)
          report_mismatch("value", out_value, want.value);
        if (out_has_sample !== want.has_sample)
          report_mismatch("has_sample", out_has_sample, want.has_sample);
        if (out_end_of_wave !== want.end_of_wave)
          report_mismatch("end_of_wave", out_end_of_wave, want.end_of_wave);
      end
    end
    stall_next = 1'b0;
    if (hold_req > 0) begin
      stall_next = 1'b1;
      hold_req--;
    end else if (stall_mode == 1) begin
      if (pat_age == 0) stall_pat = 8'($urandom);
      pat_age = (pat_age + 1) % 32;
      stall_next = stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[7:1]};
    end else if (stall_mode == 2) begin
      stall_next = ($urandom_range(0, 3) == 0);
    end
    out_stall <= stall_next;
  end

  // register extremes
  task automatic test_registers;
    cfg_write(REG_RATIO, 32'h0000_ffff);
    cfg_write(REG_RATIO, 32'h0000_0000);
    cfg_write(REG_OFFSET, 32'h0000_8000);
    cfg_write(REG_OFFSET, 32'd4032);
    cfg_write(REG_MASK, 32'hffff_ffff);
    cfg_write(REG_MASK, 32'h0000_0000);
    cfg_write(REG_RATIO, 32'd4096);
    cfg_write(REG_OFFSET, 32'd0);
  endtask

  // boards outside the mask, missing and repeated first marks
  task automatic test_pass_through;
    stall_mode = 1;
    send_item(5'd0, -16'sd32768, 1'b1, 1'b0);
    send_item(5'd31, 16'sd32767, 1'b0, 1'b1);
    send_item(5'd5, -16'sd1, 1'b0, 1'b0);
    send_item(5'd5, 16'sd0, 1'b1, 1'b1);
    drain_results();
  endtask

  // two outputs per sample with a half sample offset, full scale swings
  task automatic test_interpolation;
    cfg_write(REG_MASK, 32'hffff_ffff);
    cfg_write(REG_RATIO, 32'd2048);
    cfg_write(REG_OFFSET, 32'd2048);
    send_item(5'd1, 16'sd100, 1'b1, 1'b0);
    send_item(5'd1, 16'sd32767, 1'b0, 1'b0);
    send_item(5'd1, -16'sd32768, 1'b0, 1'b0);
    send_item(5'd1, 16'sd77, 1'b0, 1'b1);
    drain_results();
  endtask

  // result limit per item and positions left behind the previous sample
  task automatic test_dense_ratio;
    cfg_write(REG_RATIO, 32'd80);
    cfg_write(REG_OFFSET, 32'd8191);
    send_item(5'd2, -16'sd1234, 1'b1, 1'b0);
    send_item(5'd2, 16'sd32767, 1'b0, 1'b0);
    send_item(5'd2, -16'sd32768, 1'b0, 1'b0);
    send_item(5'd2, 16'sd5, 1'b0, 1'b0);
    send_item(5'd2, 16'sd900, 1'b0, 1'b1);
    drain_results();
    cfg_write(REG_RATIO, 32'd64);
    cfg_write(REG_OFFSET, 32'd4032);
    send_item(5'd3, 16'sd321, 1'b1, 1'b0);
    send_item(5'd3, -16'sd321, 1'b0, 1'b1);
    drain_results();
  endtask

  // last items with no output send an end marker
  task automatic test_sparse_ratio;
    cfg_write(REG_RATIO, 32'd65535);
    cfg_write(REG_OFFSET, 32'h0000_8000);
    send_item(5'd4, 16'sd10, 1'b1, 1'b1);
    send_item(5'd4, 16'sd11, 1'b1, 1'b0);
    send_item(5'd4, 16'sd12, 1'b0, 1'b1);
    drain_results();
  endtask

  // ratios under the minimum pass through even for selected boards
  task automatic test_min_ratio;
    cfg_write(REG_OFFSET, 32'd0);
    cfg_write(REG_RATIO, 32'd63);
    send_item(5'd6, 16'sd1000, 1'b1, 1'b0);
    send_item(5'd6, -16'sd1000, 1'b0, 1'b1);
    drain_results();
    cfg_write(REG_RATIO, 32'd0);
    send_item(5'd7, 16'sd42, 1'b1, 1'b1);
    drain_results();
  endtask

  // mask and offset are taken at the first item, ratio changes at once
  task automatic test_mode_latch;
    cfg_write(REG_RATIO, 32'd4096);
    send_item(5'd8, 16'sd2000, 1'b1, 1'b0);
    drain_results();
    cfg_write(REG_MASK, 32'd0);
    cfg_write(REG_OFFSET, 32'd2048);
    send_item(5'd8, 16'sd3000, 1'b0, 1'b0);
    drain_results();
    cfg_write(REG_RATIO, 32'd1024);
    send_item(5'd8, -16'sd3000, 1'b0, 1'b1);
    send_item(5'd8, 16'sd7, 1'b1, 1'b1);
    drain_results();
  endtask

  // long receiver hold while the sender keeps offering
  task automatic test_backpressure;
    cfg_write(REG_MASK, 32'hffff_ffff);
    cfg_write(REG_RATIO, 32'd2048);
    cfg_write(REG_OFFSET, 32'd0);
    stall_mode = 0;
    no_gaps = 1'b1;
    hold_req = 500;
    for (int i = 0; i < 45; i++)
      send_item(5'(i / 9), 16'($urandom), (i % 9) == 0, (i % 9) == 8);
    no_gaps = 1'b0;
    drain_results();
  endtask

  // random settings and waveforms with some broken framing
  task automatic test_random_waves;
    int            nwaves, len, offs;
    logic          fst, lst;
    logic [4:0]    bid;
    logic [15:0]   smp;
    logic [15:0]   ratio;
    while (items_sent < TOTAL_ITEMS) begin
      case ($urandom_range(0, 19))
        0, 1:  ratio = 16'($urandom_range(0, 63));
        2:     ratio = 16'($urandom_range(64, 255));
        3, 4:  ratio = 16'($urandom_range(256, 2047));
        5, 6:  ratio = 16'($urandom_range(8193, 65535));
        default: ratio = 16'($urandom_range(2048, 8192));
      endcase
      cfg_write(REG_RATIO, {16'd0, ratio});
      offs = $urandom_range(0, 36800) - 32768;
      if ($urandom_range(0, 3) == 0) offs = $urandom_range(0, 4032);
      cfg_write(REG_OFFSET, {16'd0, 16'(offs)});
      case ($urandom_range(0, 3))
        0:       cfg_write(REG_MASK, 32'hffff_ffff);
        1:       cfg_write(REG_MASK, 32'h0000_0000);
        default: cfg_write(REG_MASK, $urandom);
      endcase
      stall_mode = $urandom_range(0, 2);
      no_gaps = ($urandom_range(0, 3) == 0);
      nwaves = $urandom_range(2, 5);
      for (int k = 0; k < nwaves; k++) begin
        len = $urandom_range(1, 10);
        bid = 5'($urandom);
        for (int i = 0; i < len; i++) begin
          fst = (i == 0);
          lst = (i == len - 1);
          case ($urandom_range(0, 15))
            0:       fst = ~fst;
            1:       lst = ~lst;
            2:       begin fst = 1'($urandom); lst = 1'($urandom); end
            default: ;
          endcase
          case ($urandom_range(0, 9))
            0:       smp = 16'h8000;
            1:       smp = 16'h7fff;
            2:       smp = 16'hffff;
            default: smp = 16'($urandom);
          endcase
          if (fst) bid = 5'($urandom);
          send_item(bid, smp, fst, lst);
        end
      end
      no_gaps = 1'b0;
      drain_results();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_registers();
    test_pass_through();
    test_interpolation();
    test_dense_ratio();
    test_sparse_ratio();
    test_min_ratio();
    test_mode_latch();
    test_backpressure();
    test_random_waves();
    drain_results();
    if (errors == 0)
      $display("linear_interp_resampler regression: pass");
    else
      $display("linear_interp_resampler regression: fail");
    $finish;
  end

endmodule

// ----- linear_interp_resampler.f -----
rtl/lir_pkg.sv
rtl/lir_seq.sv
rtl/linear_interp_resampler.sv
tb/tb_linear_interp_resampler.sv
